FILE: sv/stereo_random_dropout_envelope_macros.svh
// Assertion helpers for the RTL top level. Each checks on the rising edge of clk
// and is ignored while rst_n is low.
`ifndef STEREO_RANDOM_DROPOUT_ENVELOPE_MACROS_SVH
`define STEREO_RANDOM_DROPOUT_ENVELOPE_MACROS_SVH
`ifndef SYNTHESIS
`define SRDE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("srde assertion failed");
`define SRDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srde assertion failed");
`else
`define SRDE_ASSERT(lbl, cond)
`define SRDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/srde_pkg.sv
package srde_pkg;

    localparam int unsigned UNITY_GAIN         = 32768;
    localparam int unsigned GAIN_LIMIT         = 3277;
    localparam int unsigned DB_STEPS           = 320;
    localparam logic [31:0] STEP_Q32           = 32'd4264173445;
    localparam logic [31:0] LCG_MUL            = 32'd1664525;
    localparam logic [31:0] LCG_ADD            = 32'd1013904223;
    localparam int unsigned CLUSTER_WINDOW_DEF = 7200;
    localparam logic [31:0] RNG_SEED_DEF       = 32'd1;
    localparam int unsigned DIV_STEPS          = 36;

    typedef enum logic [2:0] {
        REG_RATE      = 3'd0,
        REG_MONO_LINK = 3'd1,
        REG_CLUSTER   = 3'd2,
        REG_MIN_REST  = 3'd3,
        REG_DEPTH_MIN = 3'd4,
        REG_DEPTH_MAX = 3'd5,
        REG_DUR_MIN   = 3'd6,
        REG_DUR_MAX   = 3'd7
    } reg_index_t;

    typedef logic [15:0] db_rom_t [0:DB_STEPS];

    // Gain table: round(32768 * 10^(-k/320)) by repeated Q0.32 multiplication.
    function automatic db_rom_t build_db_rom();
        db_rom_t     rom;
        logic [63:0] acc;
        logic [63:0] tmp;
        acc = 64'h8000_0000;
        for (int k = 0; k <= int'(DB_STEPS); k++)
        begin
            tmp    = (acc + 64'd32768) >> 16;
            rom[k] = tmp[15:0];
            acc    = (acc * {32'd0, STEP_Q32} + 64'h8000_0000) >> 32;
        end
        return rom;
    endfunction

    localparam db_rom_t DB_ROM = build_db_rom();

    typedef struct packed {
        logic go;
        logic clear;
        logic start;
    } lane_ctrl_t;

    typedef struct packed {
        logic        active;
        logic        busy;
        logic        ended;
        logic [15:0] env;
    } lane_stat_t;

endpackage

FILE: sv/srde_lane.sv
module srde_lane
    import srde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_ctrl_t  ctrl,
    input  logic [15:0] start_gain,
    input  logic [19:0] start_dur,
    output lane_stat_t  stat
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_DIV  = 3'b010,
        L_FIN  = 3'b100
    } lane_state_t;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    lane_state_t state_reg;
    logic        active_reg;
    logic [1:0]  phase_reg;
    logic [19:0] pc_reg;
    logic [19:0] alen_reg, hlen_reg, rlen_reg;
    logic [15:0] floor_reg, env_reg;
    logic        sub_reg, last_reg, ended_reg;
    logic [35:0] quo_reg;
    logic [19:0] rem_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [15:0] drop;
    logic [19:0] n_next;
    logic [19:0] len_a, len_r, m_a, m_r;
    logic [19:0] a_len;
    logic [20:0] two_a;
    logic [19:0] r_len;
    logic [20:0] trial;
    logic        fits;

    assign drop   = 16'(UNITY_GAIN) - floor_reg;
    assign n_next = pc_reg + 20'd1;
    assign len_a  = (alen_reg != 20'd0) ? alen_reg : 20'd1;
    assign len_r  = (rlen_reg != 20'd0) ? rlen_reg : 20'd1;
    assign m_a    = (n_next < len_a) ? n_next : len_a;
    assign m_r    = (n_next < len_r) ? n_next : len_r;

    assign a_len  = (start_dur[19:2] != 18'd0) ? {2'd0, start_dur[19:2]} : 20'd1;
    assign two_a  = {a_len, 1'b0};
    assign r_len  = ({1'b0, start_dur} > two_a) ? 20'({1'b0, start_dur} - two_a) : 20'd1;

    assign trial  = {rem_reg, quo_reg[35]};
    assign fits   = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            active_reg <= 1'b0;
            phase_reg  <= 2'd0;
            pc_reg     <= 20'd0;
            alen_reg   <= 20'd0;
            hlen_reg   <= 20'd0;
            rlen_reg   <= 20'd0;
            floor_reg  <= 16'(UNITY_GAIN);
            env_reg    <= 16'(UNITY_GAIN);
            ended_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            ended_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (ctrl.clear)
                    begin
                        active_reg <= 1'b0;
                        env_reg    <= 16'(UNITY_GAIN);
                    end
                    else if (ctrl.start && !active_reg)
                    begin
                        active_reg <= 1'b1;
                        phase_reg  <= 2'd0;
                        pc_reg     <= 20'd0;
                        alen_reg   <= a_len;
                        hlen_reg   <= a_len;
                        rlen_reg   <= r_len;
                        floor_reg  <= start_gain;
                        env_reg    <= 16'(UNITY_GAIN);
                    end
                    else if (ctrl.go && active_reg)
                    begin
                        case (phase_reg)
                            2'd0:
                            begin
                                quo_reg  <= 36'(drop) * 36'(m_a);
                                den_reg  <= len_a;
                                rem_reg  <= 20'd0;
                                sub_reg  <= 1'b1;
                                last_reg <= 1'b0;
                                cnt_reg  <= '0;
                                state_reg <= L_DIV;
                                if (n_next >= alen_reg)
                                begin
                                    phase_reg <= 2'd1;
                                    pc_reg    <= 20'd0;
                                end
                                else
                                begin
                                    pc_reg <= n_next;
                                end
                            end
                            2'd1:
                            begin
                                env_reg <= floor_reg;
                                if (n_next >= hlen_reg)
                                begin
                                    phase_reg <= 2'd2;
                                    pc_reg    <= 20'd0;
                                end
                                else
                                begin
                                    pc_reg <= n_next;
                                end
                            end
                            2'd2:
                            begin
                                quo_reg  <= 36'(drop) * 36'(m_r);
                                den_reg  <= len_r;
                                rem_reg  <= 20'd0;
                                sub_reg  <= 1'b0;
                                last_reg <= (n_next >= rlen_reg);
                                cnt_reg  <= '0;
                                pc_reg   <= n_next;
                                state_reg <= L_DIV;
                            end
                            default:
                            begin
                                active_reg <= 1'b0;
                                env_reg    <= 16'(UNITY_GAIN);
                            end
                        endcase
                    end
                end
                L_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    rem_reg <= fits ? 20'(trial - {1'b0, den_reg}) : trial[19:0];
                    quo_reg <= {quo_reg[34:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN:
                begin
                    state_reg <= L_IDLE;
                    if (last_reg)
                    begin
                        active_reg <= 1'b0;
                        env_reg    <= 16'(UNITY_GAIN);
                        ended_reg  <= 1'b1;
                    end
                    else if (sub_reg)
                    begin
                        env_reg <= 16'(UNITY_GAIN) - quo_reg[15:0];
                    end
                    else
                    begin
                        env_reg <= floor_reg + quo_reg[15:0];
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign stat.active = active_reg;
    assign stat.busy   = (state_reg != L_IDLE);
    assign stat.ended  = ended_reg;
    assign stat.env    = env_reg;

endmodule

FILE: sv/srde_merge.sv
module srde_merge
    import srde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic signed [23:0] left_in,
    input  logic signed [23:0] right_in,
    input  lane_stat_t         stat_l,
    input  lane_stat_t         stat_r,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic [1:0]         m_tuser
);

    logic        valid_reg;
    logic [47:0] data_reg;
    logic [1:0]  user_reg;
    logic signed [41:0] prod_l, prod_r;

    // Rounded to nearest, ties toward plus infinity.
    assign prod_l = left_in * $signed({2'b00, stat_l.env}) + 42'sd16384;
    assign prod_r = right_in * $signed({2'b00, stat_r.env}) + 42'sd16384;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {prod_r[38:15], prod_l[38:15]};
            user_reg <= {stat_r.active, stat_l.active};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

FILE: sv/stereo_random_dropout_envelope.sv
// Stereo tape-dropout envelope. One stereo sample is taken per transaction and
// one scaled sample comes out for it. A sample marked block_start with a nonzero
// block_length runs the dropout decision, at most one random draw per cycle (up
// to six), then both channel lanes advance their envelopes; a ramp step runs a
// bit-serial divider in each lane, and the next sample is taken only once both
// lanes are idle again.
// A new sample is taken while the last result waits at the output register.
// With rate_per_sample at zero the samples pass unchanged.
`include "stereo_random_dropout_envelope_macros.svh"
module stereo_random_dropout_envelope
    import srde_pkg::*;
#(
    parameter int unsigned CLUSTER_WINDOW = CLUSTER_WINDOW_DEF,
    parameter logic [31:0] RNG_SEED       = RNG_SEED_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_sample[23:0], right_sample[47:24], block_length[60:48], zero fill
    input  logic [63:0] s_tdata,
    // block_start
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_out[23:0], right_out[47:24]
    output logic [47:0] m_tdata,
    // left_busy[0], right_busy[1]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_DEC        = 14'b00000000000010,
        S_TRIG       = 14'b00000000000100,
        S_CLUS       = 14'b00000000001000,
        S_DEPTH_DRAW = 14'b00000000010000,
        S_DEPTH_CALC = 14'b00000000100000,
        S_DUR_DRAW   = 14'b00000001000000,
        S_DUR_CALC   = 14'b00000010000000,
        S_MONO       = 14'b00000100000000,
        S_SIDE       = 14'b00001000000000,
        S_LANES      = 14'b00010000000000,
        S_WAIT       = 14'b00100000000000,
        S_OUT        = 14'b01000000000000,
        S_SETTLE     = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [31:0] rate_reg;
    logic [16:0] mono_reg, clus_prob_reg;
    logic [23:0] min_rest_reg;
    logic signed [10:0] dmin_reg, dmax_reg;
    logic [19:0] dur_min_reg, dur_max_reg;

    logic [31:0] rng_reg, draw_reg;
    logic [23:0] rest_reg;
    logic [15:0] cluster_reg;
    logic [44:0] thresh_reg;
    logic signed [23:0] left_reg, right_reg;
    logic signed [11:0] depth_reg;
    logic [15:0] gain_reg;
    logic [19:0] dur_reg;

    lane_ctrl_t ctrl_l, ctrl_r;
    lane_stat_t stat_l, stat_r;
    logic       merge_load, merge_free;

    logic        accept;
    logic [12:0] in_len;
    logic [31:0] rng_next;
    logic [16:0] clp, mlp;
    logic        any_active, clus_ok;
    logic signed [11:0] lo, hi;
    logic [11:0] dspan;
    logic [43:0] dprod;
    logic [19:0] dhi, uspan;
    logic [51:0] uprod;
    logic [19:0] dur_calc;
    logic [8:0]  rom_idx;
    logic [15:0] rom_val, gain_calc;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_len     = s_tdata[60:48];
    assign rng_next   = rng_reg * LCG_MUL + LCG_ADD;
    assign clp        = (clus_prob_reg > 17'd65536) ? 17'd65536 : clus_prob_reg;
    assign mlp        = (mono_reg > 17'd65536) ? 17'd65536 : mono_reg;
    assign any_active = stat_l.active || stat_r.active;
    assign clus_ok    = (cluster_reg != 16'd0) && (clp != 17'd0);

    assign lo    = (dmin_reg < dmax_reg) ? 12'(dmin_reg) : 12'(dmax_reg);
    assign hi    = (dmin_reg < dmax_reg) ? 12'(dmax_reg) : 12'(dmin_reg);
    assign dspan = 12'(hi - lo);
    assign dprod = draw_reg * dspan;

    assign dhi      = (dur_max_reg > dur_min_reg) ? dur_max_reg : dur_min_reg;
    assign uspan    = dhi - dur_min_reg;
    assign uprod    = draw_reg * uspan;
    assign dur_calc = dur_min_reg + uprod[51:32];

    assign rom_idx = 9'(-depth_reg);
    assign rom_val = DB_ROM[rom_idx];
    always_comb
    begin
        if (depth_reg >= 12'sd0)
        begin
            gain_calc = 16'(UNITY_GAIN);
        end
        else if (depth_reg < -$signed(12'(DB_STEPS)))
        begin
            gain_calc = 16'(GAIN_LIMIT);
        end
        else
        begin
            gain_calc = (rom_val < 16'(GAIN_LIMIT)) ? 16'(GAIN_LIMIT) : rom_val;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= 32'd0;
            mono_reg      <= 17'd0;
            clus_prob_reg <= 17'd0;
            min_rest_reg  <= 24'd0;
            dmin_reg      <= -11'sd320;
            dmax_reg      <= -11'sd80;
            dur_min_reg   <= 20'd480;
            dur_max_reg   <= 20'd4800;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_RATE:      rate_reg      <= cfg_data;
                REG_MONO_LINK: mono_reg      <= cfg_data[16:0];
                REG_CLUSTER:   clus_prob_reg <= cfg_data[16:0];
                REG_MIN_REST:  min_rest_reg  <= cfg_data[23:0];
                REG_DEPTH_MIN: dmin_reg      <= cfg_data[10:0];
                REG_DEPTH_MAX: dmax_reg      <= cfg_data[10:0];
                REG_DUR_MIN:   dur_min_reg   <= cfg_data[19:0];
                REG_DUR_MAX:   dur_max_reg   <= cfg_data[19:0];
                default:       rate_reg      <= rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg   <= s_tdata[23:0];
            right_reg  <= s_tdata[47:24];
            thresh_reg <= rate_reg * in_len;
        end
        if (state_reg == S_DEPTH_DRAW || state_reg == S_DUR_DRAW)
        begin
            draw_reg <= rng_next;
        end
        if (state_reg == S_DEPTH_CALC)
        begin
            depth_reg <= 12'(lo + $signed({1'b0, dprod[43:32]}));
        end
        if (state_reg == S_DUR_DRAW)
        begin
            gain_reg <= gain_calc;
        end
        if (state_reg == S_DUR_CALC)
        begin
            dur_reg <= (dur_calc == 20'd0) ? 20'd1 : dur_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rng_reg     <= RNG_SEED;
            rest_reg    <= 24'd0;
            cluster_reg <= 16'd0;
        end
        else
        begin
            if (stat_l.ended || stat_r.ended)
            begin
                if (rest_reg < min_rest_reg)
                begin
                    rest_reg <= min_rest_reg;
                end
                cluster_reg <= 16'(CLUSTER_WINDOW);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (rate_reg == 32'd0)
                        begin
                            state_reg <= S_SETTLE;
                        end
                        else if (s_tuser && in_len != 13'd0)
                        begin
                            rest_reg <= (rest_reg > 24'(in_len)) ?
                                        rest_reg - 24'(in_len) : 24'd0;
                            cluster_reg <= (cluster_reg > 16'(in_len)) ?
                                           cluster_reg - 16'(in_len) : 16'd0;
                            state_reg <= S_DEC;
                        end
                        else
                        begin
                            state_reg <= S_LANES;
                        end
                    end
                end
                S_DEC:
                begin
                    if (!any_active && rest_reg == 24'd0)
                    begin
                        state_reg <= S_TRIG;
                    end
                    else if (!any_active && clus_ok)
                    begin
                        state_reg <= S_CLUS;
                    end
                    else
                    begin
                        state_reg <= S_LANES;
                    end
                end
                S_TRIG:
                begin
                    rng_reg <= rng_next;
                    if ({13'd0, rng_next} < thresh_reg)
                    begin
                        state_reg <= S_DEPTH_DRAW;
                    end
                    else if (clus_ok)
                    begin
                        state_reg <= S_CLUS;
                    end
                    else
                    begin
                        state_reg <= S_LANES;
                    end
                end
                S_CLUS:
                begin
                    rng_reg <= rng_next;
                    if ({1'b0, rng_next} < {clp, 16'd0})
                    begin
                        cluster_reg <= 16'd0;
                        state_reg   <= S_DEPTH_DRAW;
                    end
                    else
                    begin
                        state_reg <= S_LANES;
                    end
                end
                S_DEPTH_DRAW:
                begin
                    rng_reg   <= rng_next;
                    state_reg <= S_DEPTH_CALC;
                end
                S_DEPTH_CALC:
                begin
                    state_reg <= S_DUR_DRAW;
                end
                S_DUR_DRAW:
                begin
                    rng_reg   <= rng_next;
                    state_reg <= S_DUR_CALC;
                end
                S_DUR_CALC:
                begin
                    state_reg <= S_MONO;
                end
                S_MONO:
                begin
                    rng_reg   <= rng_next;
                    state_reg <= ({1'b0, rng_next} < {mlp, 16'd0}) ? S_LANES : S_SIDE;
                end
                S_SIDE:
                begin
                    rng_reg   <= rng_next;
                    state_reg <= S_LANES;
                end
                S_LANES:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!stat_l.busy && !stat_r.busy)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SETTLE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (merge_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    logic mono_hit;
    assign mono_hit = ({1'b0, rng_next} < {mlp, 16'd0});

    always_comb
    begin
        ctrl_l = '0;
        ctrl_r = '0;
        if (state_reg == S_IDLE && accept && rate_reg == 32'd0)
        begin
            ctrl_l.clear = 1'b1;
            ctrl_r.clear = 1'b1;
        end
        if (state_reg == S_MONO && mono_hit)
        begin
            ctrl_l.start = 1'b1;
            ctrl_r.start = 1'b1;
        end
        if (state_reg == S_SIDE)
        begin
            ctrl_l.start = !rng_next[31];
            ctrl_r.start = rng_next[31];
        end
        if (state_reg == S_LANES)
        begin
            ctrl_l.go = 1'b1;
            ctrl_r.go = 1'b1;
        end
    end

    assign merge_load = (state_reg == S_OUT) && merge_free;

    srde_lane u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_l),
        .start_gain (gain_reg),
        .start_dur  (dur_reg),
        .stat       (stat_l)
    );

    srde_lane u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_r),
        .start_gain (gain_reg),
        .start_dur  (dur_reg),
        .stat       (stat_r)
    );

    srde_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (merge_load),
        .left_in  (left_reg),
        .right_in (right_reg),
        .stat_l   (stat_l),
        .stat_r   (stat_r),
        .free     (merge_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A new sample is never taken while a lane is still working on the last one.
    `SRDE_ASSERT(a_idle_lanes, !s_tready || (!stat_l.busy && !stat_r.busy))
    // The cluster window timer never exceeds its reload value.
    `SRDE_ASSERT(a_cluster_range, cluster_reg <= 16'(CLUSTER_WINDOW))
    // Once an event ends, the rest timer covers at least the minimum rest.
    `SRDE_ASSERT_NEXT(a_rest_after_end, (stat_l.ended || stat_r.ended) && !cfg_we,
        rest_reg >= $past(min_rest_reg))

endmodule

FILE: dv/tb_stereo_random_dropout_envelope.sv
`timescale 1ns / 1ps

module tb_stereo_random_dropout_envelope;
    import srde_pkg::*;

    localparam int unsigned WINDOW = 7200;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [23:0] left_out;
        logic [23:0] right_out;
        logic        left_busy;
        logic        right_busy;
    } scaled_sample_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    scaled_sample_t expected_samples[$];
    int  error_count;
    bit  hold_req;

    // Predictor copy of the registers.
    bit [31:0] rate_q32;
    bit [16:0] mono_q16;
    bit [16:0] cluster_q16;
    bit [23:0] min_rest;
    int        depth_a;
    int        depth_b;
    bit [19:0] dur_lo;
    bit [19:0] dur_hi;

    // Predictor copy of the state.
    bit [31:0] lcg;
    bit [31:0] rest_cnt;
    bit [31:0] window_cnt;
    bit        lane_on[2];
    bit [1:0]  lane_phase[2];
    bit [31:0] lane_count[2];
    bit [31:0] lane_attack[2];
    bit [31:0] lane_hold[2];
    bit [31:0] lane_release[2];
    bit [31:0] lane_floor[2];
    bit [31:0] lane_env[2];
    bit [15:0] gain_rom[0:320];

    stereo_random_dropout_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void reset_predictor();
        longint unsigned acc;
        acc = 64'h8000_0000;
        for (int k = 0; k <= 320; k++)
        begin
            gain_rom[k] = 16'((acc + 64'd32768) >> 16);
            acc = (acc * 64'd4264173445 + 64'h8000_0000) >> 32;
        end
        rate_q32 = 0; mono_q16 = 0; cluster_q16 = 0; min_rest = 0;
        depth_a = -320; depth_b = -80; dur_lo = 480; dur_hi = 4800;
        lcg = 32'd1; rest_cnt = 0; window_cnt = 0;
        for (int c = 0; c < 2; c++)
        begin
            lane_on[c] = 0; lane_phase[c] = 0; lane_count[c] = 0;
            lane_attack[c] = 0; lane_hold[c] = 0; lane_release[c] = 0;
            lane_floor[c] = 32768; lane_env[c] = 32768;
        end
    endfunction

    function automatic bit [31:0] next_draw();
        lcg = lcg * 32'd1664525 + 32'd1013904223;
        return lcg;
    endfunction

    function automatic bit [31:0] floor_from_depth(int depth);
        if (depth >= 0)
            return 32768;
        if (depth < -320)
            return 3277;
        return (gain_rom[-depth] < 3277) ? 32'd3277 : 32'(gain_rom[-depth]);
    endfunction

    function automatic void open_event(int c, int depth, bit [31:0] total);
        bit [31:0] a;
        if (lane_on[c])
            return;
        a = total >> 2;
        if (a < 1)
            a = 1;
        lane_on[c] = 1;
        lane_phase[c] = 0;
        lane_count[c] = 0;
        lane_attack[c] = a;
        lane_hold[c] = a;
        lane_release[c] = (total > 2 * a) ? total - 2 * a : 1;
        lane_floor[c] = floor_from_depth(depth);
        lane_env[c] = 32768;
    endfunction

    function automatic bit [31:0] step_lane(int c);
        longint unsigned drop;
        bit [31:0] n;
        bit [31:0] len;
        if (!lane_on[c])
            return 32768;
        drop = 32768 - lane_floor[c];
        case (lane_phase[c])
            2'd0:
            begin
                n = (lane_count[c] + 1) & 32'hFFFFF;
                lane_count[c] = n;
                len = lane_attack[c] ? lane_attack[c] : 1;
                lane_env[c] = 32768 - 32'((drop * ((n < len) ? n : len)) / len);
                if (n >= lane_attack[c])
                begin
                    lane_phase[c] = 1;
                    lane_count[c] = 0;
                end
            end
            2'd1:
            begin
                lane_env[c] = lane_floor[c];
                n = (lane_count[c] + 1) & 32'hFFFFF;
                lane_count[c] = n;
                if (n >= lane_hold[c])
                begin
                    lane_phase[c] = 2;
                    lane_count[c] = 0;
                end
            end
            2'd2:
            begin
                n = (lane_count[c] + 1) & 32'hFFFFF;
                lane_count[c] = n;
                len = lane_release[c] ? lane_release[c] : 1;
                lane_env[c] = lane_floor[c] + 32'((drop * ((n < len) ? n : len)) / len);
                if (n >= lane_release[c])
                begin
                    lane_on[c] = 0;
                    lane_env[c] = 32768;
                    if (rest_cnt < min_rest)
                        rest_cnt = min_rest;
                    window_cnt = WINDOW;
                end
            end
            default:
            begin
                lane_on[c] = 0;
                lane_env[c] = 32768;
            end
        endcase
        return lane_env[c];
    endfunction

    function automatic void decide_block(bit [31:0] len);
        bit any;
        bit fire;
        longint unsigned clp;
        longint unsigned mlp;
        int lo;
        int hi;
        int depth;
        bit [31:0] top;
        bit [31:0] dur;
        any = lane_on[0] || lane_on[1];
        fire = 0;
        clp = (cluster_q16 > 65536) ? 65536 : cluster_q16;
        mlp = (mono_q16 > 65536) ? 65536 : mono_q16;
        rest_cnt = (rest_cnt > len) ? rest_cnt - len : 0;
        window_cnt = (window_cnt > len) ? window_cnt - len : 0;
        if (!any && rest_cnt == 0)
            fire = 64'(next_draw()) < 64'(rate_q32) * 64'(len);
        if (!fire && !any && window_cnt > 0 && clp > 0)
        begin
            if (64'(next_draw()) < (clp << 16))
            begin
                fire = 1;
                window_cnt = 0;
            end
        end
        if (fire)
        begin
            lo = (depth_a < depth_b) ? depth_a : depth_b;
            hi = (depth_a < depth_b) ? depth_b : depth_a;
            depth = lo + int'((64'(next_draw()) * 64'(hi - lo)) >> 32);
            top = (dur_hi > dur_lo) ? dur_hi : dur_lo;
            dur = dur_lo + 32'((64'(next_draw()) * 64'(top - dur_lo)) >> 32);
            if (dur < 1)
                dur = 1;
            if (64'(next_draw()) < (mlp << 16))
            begin
                open_event(0, depth, dur);
                open_event(1, depth, dur);
            end
            else
                open_event((next_draw() < 32'h8000_0000) ? 0 : 1, depth, dur);
        end
    endfunction

    function automatic bit [23:0] apply_gain(bit [23:0] raw, bit [31:0] g);
        longint p;
        p = longint'($signed(raw)) * longint'(g) + 16384;
        return 24'(p >>> 15);
    endfunction

    function automatic scaled_sample_t predict_sample(bit [23:0] l, bit [23:0] r,
                                                     bit bs, bit [12:0] len);
        scaled_sample_t res;
        bit [31:0] gl;
        bit [31:0] gr;
        if (rate_q32 == 0)
        begin
            lane_on[0] = 0; lane_on[1] = 0;
            lane_env[0] = 32768; lane_env[1] = 32768;
            res.left_out = l; res.right_out = r;
            res.left_busy = 0; res.right_busy = 0;
            return res;
        end
        if (bs && len > 0)
            decide_block(len);
        gl = step_lane(0);
        gr = step_lane(1);
        res.left_out = apply_gain(l, gl);
        res.right_out = apply_gain(r, gr);
        res.left_busy = lane_on[0];
        res.right_busy = lane_on[1];
        return res;
    endfunction

    function automatic void store_register(reg_index_t idx, bit [31:0] v);
        case (idx)
            REG_RATE:      rate_q32 = v;
            REG_MONO_LINK: mono_q16 = v[16:0];
            REG_CLUSTER:   cluster_q16 = v[16:0];
            REG_MIN_REST:  min_rest = v[23:0];
            REG_DEPTH_MIN: depth_a = int'($signed(v[10:0]));
            REG_DEPTH_MAX: depth_b = int'($signed(v[10:0]));
            REG_DUR_MIN:   dur_lo = v[19:0];
            REG_DUR_MAX:   dur_hi = v[19:0];
            default: ;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transaction happens.
    task automatic send_sample(bit [23:0] l, bit [23:0] r, bit bs, bit [12:0] len);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, len, r, l};
        s_tuser  <= bs;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        expected_samples.push_back(predict_sample(l, r, bs, len));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, bit [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        store_register(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_sample(int max_len);
        bit bs;
        bit [12:0] len;
        bs = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 19) == 0)
            len = 13'($urandom_range(0, 4096));
        else
            len = 13'($urandom_range(1, max_len));
        send_sample(24'($urandom), 24'($urandom), bs, len);
    endtask

    task automatic test_bypass();
        write_register(REG_RATE, 32'd0);
        send_sample(24'h800000, 24'h7FFFFF, 1'b1, 13'd1);
        send_sample(24'h7FFFFF, 24'h800000, 1'b1, 13'd4096);
        send_sample(24'h000000, 24'hFFFFFF, 1'b0, 13'd0);
        drain();
    endtask

    task automatic test_extremes();
        write_register(REG_MONO_LINK, 32'd65536);
        write_register(REG_CLUSTER, 32'd65536);
        write_register(REG_MIN_REST, 32'd0);
        write_register(REG_DEPTH_MIN, 32'h7C0);   // -64 in sixteenths
        write_register(REG_DEPTH_MAX, 32'h440);   // -960, past the table end
        write_register(REG_DUR_MIN, 32'd0);
        write_register(REG_DUR_MAX, 32'd9);
        write_register(REG_RATE, 32'hFFFF_FFFF);
        // A zero block length makes no decision.
        send_sample(24'h400000, 24'hC00000, 1'b1, 13'd0);
        send_sample(24'h7FFFFF, 24'h800000, 1'b1, 13'd1);
        for (int i = 0; i < 12; i++)
            send_sample(24'h7FFFFF, 24'h800000, 1'(i % 3 == 0), 13'd4096);
        drain();
        // Rate back to zero clears the running events.
        write_register(REG_RATE, 32'd0);
        send_sample(24'h123456, 24'hFEDCBA, 1'b1, 13'd7);
        drain();
        write_register(REG_DEPTH_MIN, 32'h3FF);   // positive depth gives unity
        write_register(REG_DEPTH_MAX, 32'h000);
        write_register(REG_MONO_LINK, 32'h1FFFF);
        write_register(REG_CLUSTER, 32'h1FFFF);
        write_register(REG_RATE, 32'h8000_0000);
        for (int i = 0; i < 6; i++)
            send_sample(24'h7FFFFF, 24'h800001, 1'b1, 13'd3);
        drain();
    endtask

    task automatic test_random_phase(int count, int max_len);
        bit [31:0] v;
        v = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(1, 32'h0FFF_FFFF)) : $urandom;
        write_register(REG_RATE, (v == 0) ? 32'd1 : v);
        write_register(REG_MONO_LINK, 32'($urandom_range(0, 131071)));
        write_register(REG_CLUSTER, 32'($urandom_range(0, 131071)));
        write_register(REG_MIN_REST, ($urandom_range(0, 3) == 0) ? 32'($urandom) & 32'hFFFFFF
                                                                : 32'($urandom_range(0, 40)));
        write_register(REG_DEPTH_MIN, 32'($urandom_range(0, 2047)));
        write_register(REG_DEPTH_MAX, 32'($urandom_range(0, 2047)));
        write_register(REG_DUR_MIN, 32'($urandom_range(0, 30)));
        write_register(REG_DUR_MAX, ($urandom_range(0, 7) == 0) ? 32'($urandom) & 32'hFFFFF
                                                                : 32'($urandom_range(0, 60)));
        for (int i = 0; i < count; i++)
            send_random_sample(max_len);
        drain();
    endtask

    task automatic test_backpressure();
        // The receiver stops for a long stretch while samples keep coming.
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_random_sample(8);
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_RATE;
        cfg_data  = '0;
        error_count = 0;
        hold_req = 1'b0;
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bypass();
        test_extremes();
        test_random_phase(300, 16);
        test_backpressure();
        test_random_phase(300, 64);
        test_random_phase(300, 4);
        test_random_phase(280, 32);
        drain();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, one long hold when asked, and the result check.
    initial
    begin
        scaled_sample_t want;
        int n;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = $urandom_range(0, 3);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            if (expected_samples.size() == 0)
            begin
                $error("result transaction with no sample pending");
                error_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata[23:0] !== want.left_out)
                begin
                    $error("left_out expected %h got %h", want.left_out, m_tdata[23:0]);
                    error_count++;
                end
                if (m_tdata[47:24] !== want.right_out)
                begin
                    $error("right_out expected %h got %h", want.right_out, m_tdata[47:24]);
                    error_count++;
                end
                if (m_tuser[0] !== want.left_busy)
                begin
                    $error("left_busy expected %b got %b", want.left_busy, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.right_busy)
                begin
                    $error("right_busy expected %b got %b", want.right_busy, m_tuser[1]);
                    error_count++;
                end
            end
            @(posedge clk);
        end
    end

endmodule
